FILE: rtl/core/cqsc_pkg.sv
package cqsc_pkg;

    localparam int COORD_BITS   = 16;
    localparam int NUM_EDGES    = 4;
    localparam int EDGE_WRAP    = 3;
    localparam int CFG_REGS     = 2 * NUM_EDGES;
    localparam int CFG_IDX_BITS = $clog2(CFG_REGS);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int SIDE_W       = PROD_W + 1;
    localparam int MAG_W        = PROD_W;
    localparam int DEN_W        = MAG_W + 1;
    localparam int NUM_W        = MAG_W + COORD_BITS + 2;
    localparam int STEP_BITS    = $clog2(COORD_BITS);

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic   action;
        coord_t first_x;
        coord_t first_y;
        coord_t second_x;
        coord_t second_y;
    } seg_item_t;

    typedef struct packed {
        logic   visible;
        coord_t clipped_first_x;
        coord_t clipped_first_y;
        coord_t clipped_second_x;
        coord_t clipped_second_y;
    } res_item_t;

    typedef struct packed {
        logic   action;
        logic   keep;
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
    } item_t;

    typedef struct packed {
        item_t                  item;
        logic                   update;
        logic                   n1;
        logic                   negx;
        logic                   negy;
        logic [COORD_BITS-1:0]  magx;
        logic [COORD_BITS-1:0]  magy;
        logic [NUM_W-1:0]       remx;
        logic [NUM_W-1:0]       remy;
        logic [DEN_W:0]         den2;
        logic [COORD_BITS-1:0]  qx;
        logic [COORD_BITS-1:0]  qy;
    } div_t;

endpackage

FILE: rtl/core/convex_quad_segment_clipper.sv
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we                 cfg_index, cfg_data
// seg       in         seg_valid / seg_ready  seg (action, endpoints)
// res       out        res_valid / res_ready  res (visible, clipped endpoints)
//
// One transfer per cycle unless a result stalls; the depth is set by the
// 16 restoring division steps for the crossing in each edge cell.
// Reset clears the corners to zero and empties the pipeline.
// A stalled result holds the whole chain; seg_ready is low only then.
module convex_quad_segment_clipper (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cqsc_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  cqsc_pkg::coord_t                  cfg_data,
    input  logic                              seg_valid,
    output logic                              seg_ready,
    input  cqsc_pkg::seg_item_t               seg,
    output logic                              res_valid,
    input  logic                              res_ready,
    output cqsc_pkg::res_item_t               res
);
    import cqsc_pkg::*;

    coord_t corner_reg  [CFG_REGS];
    coord_t corner_next [CFG_REGS];
    logic   adv;
    logic   link_valid [NUM_EDGES+1];
    item_t  link_item  [NUM_EDGES+1];

    always_comb
    begin
        corner_next = corner_reg;
        if (cfg_we)
        begin
            corner_next[cfg_index] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
            begin
                corner_reg[i] <= '0;
            end
        end
        else
        begin
            corner_reg <= corner_next;
        end
    end

    assign adv       = !res_valid || res_ready;
    assign seg_ready = adv;

    always_comb
    begin
        link_valid[0]        = seg_valid;
        link_item[0].action  = seg.action;
        link_item[0].keep    = 1'b1;
        link_item[0].x1      = seg.first_x;
        link_item[0].y1      = seg.first_y;
        link_item[0].x2      = seg.second_x;
        link_item[0].y2      = seg.second_y;
    end

    for (genvar k = 0; k < NUM_EDGES; k++)
    begin : g_edge
        localparam int NK = (k + 1) & EDGE_WRAP;
        cqsc_edge_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .qx        (corner_reg[2*k]),
            .qy        (corner_reg[2*k+1]),
            .nx        (corner_reg[2*NK]),
            .ny        (corner_reg[2*NK+1]),
            .in_valid  (link_valid[k]),
            .in_item   (link_item[k]),
            .out_valid (link_valid[k+1]),
            .out_item  (link_item[k+1])
        );
    end

    always_comb
    begin
        res_valid   = link_valid[NUM_EDGES];
        res.visible = link_item[NUM_EDGES].keep;
        res.clipped_first_x  = '0;
        res.clipped_first_y  = '0;
        res.clipped_second_x = '0;
        res.clipped_second_y = '0;
        if (link_item[NUM_EDGES].keep && link_item[NUM_EDGES].action)
        begin
            res.clipped_first_x  = link_item[NUM_EDGES].x1;
            res.clipped_first_y  = link_item[NUM_EDGES].y1;
            res.clipped_second_x = link_item[NUM_EDGES].x2;
            res.clipped_second_y = link_item[NUM_EDGES].y2;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.visible
        |-> res.clipped_first_x == '0 && res.clipped_first_y == '0
            && res.clipped_second_x == '0 && res.clipped_second_y == '0)
        else $error("rejected result carries coordinates");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("waiting result changed before its transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> seg_ready)
        else $error("input stalled with no result waiting");

endmodule

FILE: rtl/core/cqsc_div_step.sv
module cqsc_div_step (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [cqsc_pkg::STEP_BITS-1:0]  shift,
    input  logic                            in_valid,
    input  cqsc_pkg::div_t                  in_data,
    output logic                            out_valid,
    output cqsc_pkg::div_t                  out_data
);
    import cqsc_pkg::*;

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [NUM_W-1:0] dsh;
    logic             bx;
    logic             by;

    always_comb
    begin
        dsh = NUM_W'(in_data.den2) << shift;
        bx = in_data.remx >= dsh;
        by = in_data.remy >= dsh;
        data_next = in_data;
        data_next.remx = bx ? in_data.remx - dsh : in_data.remx;
        data_next.remy = by ? in_data.remy - dsh : in_data.remy;
        data_next.qx = {in_data.qx[COORD_BITS-2:0], bx};
        data_next.qy = {in_data.qy[COORD_BITS-2:0], by};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/cqsc_edge_cell.sv
module cqsc_edge_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  cqsc_pkg::coord_t  qx,
    input  cqsc_pkg::coord_t  qy,
    input  cqsc_pkg::coord_t  nx,
    input  cqsc_pkg::coord_t  ny,
    input  logic              in_valid,
    input  cqsc_pkg::item_t   in_item,
    output logic              out_valid,
    output cqsc_pkg::item_t   out_item
);
    import cqsc_pkg::*;

    typedef struct packed {
        item_t                    item;
        logic signed [PROD_W-1:0] p1a;
        logic signed [PROD_W-1:0] p1b;
        logic signed [PROD_W-1:0] p2a;
        logic signed [PROD_W-1:0] p2b;
    } prod_st_t;

    typedef struct packed {
        item_t                    item;
        logic signed [SIDE_W-1:0] v1;
        logic signed [SIDE_W-1:0] v2;
    } side_st_t;

    typedef struct packed {
        item_t                 item;
        logic                  update;
        logic                  n1;
        logic                  negx;
        logic                  negy;
        logic [COORD_BITS-1:0] magx;
        logic [COORD_BITS-1:0] magy;
        logic [MAG_W-1:0]      a;
        logic [DEN_W-1:0]      d;
    } cls_st_t;

    typedef struct packed {
        item_t                 item;
        logic                  update;
        logic                  n1;
        logic                  negx;
        logic                  negy;
        logic [COORD_BITS-1:0] magx;
        logic [COORD_BITS-1:0] magy;
        logic [NUM_W-1:0]      mx;
        logic [NUM_W-1:0]      my;
        logic [DEN_W-1:0]      d;
    } mul_st_t;

    logic signed [DIFF_W-1:0] ex;
    logic signed [DIFF_W-1:0] ey;
    logic signed [DIFF_W-1:0] d1x;
    logic signed [DIFF_W-1:0] d1y;
    logic signed [DIFF_W-1:0] d2x;
    logic signed [DIFF_W-1:0] d2y;
    logic signed [DIFF_W-1:0] dlx;
    logic signed [DIFF_W-1:0] dly;
    logic signed [SIDE_W-1:0] nv1;
    logic signed [SIDE_W-1:0] nv2;
    logic                     n1;
    logic                     n2;
    logic                     np1;
    logic                     np2;
    logic                     rej;
    logic                     crosses;
    logic [MAG_W-1:0]         b;

    logic     s1_valid_reg;
    logic     s2_valid_reg;
    logic     s3_valid_reg;
    logic     s4_valid_reg;
    logic     s5_valid_reg;
    logic     out_valid_reg;
    prod_st_t s1_reg;
    prod_st_t s1_next;
    side_st_t s2_reg;
    side_st_t s2_next;
    cls_st_t  s3_reg;
    cls_st_t  s3_next;
    mul_st_t  s4_reg;
    mul_st_t  s4_next;
    div_t     s5_reg;
    div_t     s5_next;
    item_t    out_reg;
    item_t    out_next;

    logic                  dv_valid [COORD_BITS+1];
    div_t                  dv_data  [COORD_BITS+1];
    logic signed [DIFF_W-1:0] cx;
    logic signed [DIFF_W-1:0] cy;

    always_comb
    begin
        ex  = DIFF_W'(nx) - DIFF_W'(qx);
        ey  = DIFF_W'(ny) - DIFF_W'(qy);
        d1x = DIFF_W'(in_item.x1) - DIFF_W'(qx);
        d1y = DIFF_W'(in_item.y1) - DIFF_W'(qy);
        d2x = DIFF_W'(in_item.x2) - DIFF_W'(qx);
        d2y = DIFF_W'(in_item.y2) - DIFF_W'(qy);
        s1_next.item = in_item;
        s1_next.p1a  = d1x * ey;
        s1_next.p1b  = d1y * ex;
        s1_next.p2a  = d2x * ey;
        s1_next.p2b  = d2y * ex;
    end

    always_comb
    begin
        s2_next.item = s1_reg.item;
        s2_next.v1   = SIDE_W'(s1_reg.p1a) - SIDE_W'(s1_reg.p1b);
        s2_next.v2   = SIDE_W'(s1_reg.p2a) - SIDE_W'(s1_reg.p2b);
    end

    always_comb
    begin
        n1      = s2_reg.v1[SIDE_W-1];
        n2      = s2_reg.v2[SIDE_W-1];
        np1     = n1 || (s2_reg.v1 == '0);
        np2     = n2 || (s2_reg.v2 == '0);
        rej     = !n1 && !n2;
        crosses = !(np1 && np2);
        nv1     = -s2_reg.v1;
        nv2     = -s2_reg.v2;
        b       = n2 ? MAG_W'(nv2) : MAG_W'(s2_reg.v2);
        dlx     = DIFF_W'(s2_reg.item.x2) - DIFF_W'(s2_reg.item.x1);
        dly     = DIFF_W'(s2_reg.item.y2) - DIFF_W'(s2_reg.item.y1);
        s3_next.item = s2_reg.item;
        s3_next.a    = n1 ? MAG_W'(nv1) : MAG_W'(s2_reg.v1);
        s3_next.d    = DEN_W'(s3_next.a) + DEN_W'(b);
        s3_next.n1   = n1;
        s3_next.negx = dlx[DIFF_W-1];
        s3_next.negy = dly[DIFF_W-1];
        s3_next.magx = dlx[DIFF_W-1] ? COORD_BITS'(-dlx) : COORD_BITS'(dlx);
        s3_next.magy = dly[DIFF_W-1] ? COORD_BITS'(-dly) : COORD_BITS'(dly);
        if (s2_reg.item.action)
        begin
            s3_next.item.keep = s2_reg.item.keep && !rej;
            s3_next.update    = s2_reg.item.keep && !rej && crosses;
        end
        else
        begin
            s3_next.item.keep = s2_reg.item.keep && n1;
            s3_next.update    = 1'b0;
        end
    end

    always_comb
    begin
        s4_next.item   = s3_reg.item;
        s4_next.update = s3_reg.update;
        s4_next.n1     = s3_reg.n1;
        s4_next.negx   = s3_reg.negx;
        s4_next.negy   = s3_reg.negy;
        s4_next.magx   = s3_reg.magx;
        s4_next.magy   = s3_reg.magy;
        s4_next.mx     = NUM_W'(s3_reg.a) * NUM_W'({s3_reg.magx, 1'b0});
        s4_next.my     = NUM_W'(s3_reg.a) * NUM_W'({s3_reg.magy, 1'b0});
        s4_next.d      = s3_reg.d;
    end

    always_comb
    begin
        s5_next.item   = s4_reg.item;
        s5_next.update = s4_reg.update;
        s5_next.n1     = s4_reg.n1;
        s5_next.negx   = s4_reg.negx;
        s5_next.negy   = s4_reg.negy;
        s5_next.magx   = s4_reg.magx;
        s5_next.magy   = s4_reg.magy;
        s5_next.remx   = s4_reg.mx + NUM_W'(s4_reg.d);
        s5_next.remy   = s4_reg.my + NUM_W'(s4_reg.d);
        s5_next.den2   = {s4_reg.d, 1'b0};
        s5_next.qx     = '0;
        s5_next.qy     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= dv_valid[COORD_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            s3_reg  <= s3_next;
            s4_reg  <= s4_next;
            s5_reg  <= s5_next;
            out_reg <= out_next;
        end
    end

    assign dv_valid[0] = s5_valid_reg;
    assign dv_data[0]  = s5_reg;

    for (genvar i = 0; i < COORD_BITS; i++)
    begin : g_div
        cqsc_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .shift     (STEP_BITS'(COORD_BITS - 1 - i)),
            .in_valid  (dv_valid[i]),
            .in_data   (dv_data[i]),
            .out_valid (dv_valid[i+1]),
            .out_data  (dv_data[i+1])
        );
    end

    always_comb
    begin
        cx = dv_data[COORD_BITS].negx
           ? DIFF_W'(dv_data[COORD_BITS].item.x1) - DIFF_W'(dv_data[COORD_BITS].qx)
           : DIFF_W'(dv_data[COORD_BITS].item.x1) + DIFF_W'(dv_data[COORD_BITS].qx);
        cy = dv_data[COORD_BITS].negy
           ? DIFF_W'(dv_data[COORD_BITS].item.y1) - DIFF_W'(dv_data[COORD_BITS].qy)
           : DIFF_W'(dv_data[COORD_BITS].item.y1) + DIFF_W'(dv_data[COORD_BITS].qy);
        out_next = dv_data[COORD_BITS].item;
        if (dv_data[COORD_BITS].update)
        begin
            if (!dv_data[COORD_BITS].n1)
            begin
                out_next.x1 = COORD_BITS'(cx);
                out_next.y1 = COORD_BITS'(cy);
            end
            else
            begin
                out_next.x2 = COORD_BITS'(cx);
                out_next.y2 = COORD_BITS'(cy);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // The rounded crossing never lies beyond the far endpoint.
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[COORD_BITS] && dv_data[COORD_BITS].update
        |-> dv_data[COORD_BITS].qx <= dv_data[COORD_BITS].magx)
        else $error("x offset exceeds segment extent");

    assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[COORD_BITS] && dv_data[COORD_BITS].update
        |-> dv_data[COORD_BITS].qy <= dv_data[COORD_BITS].magy)
        else $error("y offset exceeds segment extent");

    assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && s3_reg.update |-> s3_reg.item.keep && s3_reg.item.action)
        else $error("crossing scheduled for a dropped or point item");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cqsc_pkg::*;

    localparam int CORNER0_X = 0;
    localparam int CORNER0_Y = 1;
    localparam int CORNER1_X = 2;
    localparam int CORNER1_Y = 3;
    localparam int CORNER2_X = 4;
    localparam int CORNER2_Y = 5;
    localparam int CORNER3_X = 6;
    localparam int CORNER3_Y = 7;
    localparam logic ACT_POINT = 1'b0;
    localparam logic ACT_CLIP  = 1'b1;
    localparam int SETTLE_CYCLES = 120;
    localparam longint CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    coord_t cfg_data;
    logic seg_valid;
    logic seg_ready;
    seg_item_t seg;
    logic res_valid;
    logic res_ready;
    res_item_t res;

    coord_t corner_q [CFG_REGS];
    res_item_t clip_q [$];
    int mismatch_count;
    longint cycle_count;
    int rx_stall_left;
    int long_hold_cycles;
    bit quiet;

    convex_quad_segment_clipper uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .seg_valid(seg_valid),
        .seg_ready(seg_ready),
        .seg(seg),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint side_of(int k, longint px, longint py);
        int nk;
        longint qx, qy, ex, ey;
        begin
            nk = (k + 1) & EDGE_WRAP;
            qx = corner_q[2 * k];
            qy = corner_q[2 * k + 1];
            ex = longint'(corner_q[2 * nk]) - qx;
            ey = longint'(corner_q[2 * nk + 1]) - qy;
            return (px - qx) * ey - (py - qy) * ex;
        end
    endfunction

    function automatic longint crossing_of(longint c1, longint c2, longint a, longint d);
        longint delta;
        longint unsigned mag, off;
        begin
            delta = c2 - c1;
            mag = (delta < 0) ? -delta : delta;
            off = (longint'(a) * 2 * mag + d) / (2 * d);
            return (delta < 0) ? c1 - longint'(off) : c1 + longint'(off);
        end
    endfunction

    function automatic res_item_t clip_predict(seg_item_t s);
        res_item_t r;
        longint x1, y1, x2, y2, v1, v2, a, d, nx, ny;
        bit keep;
        begin
            r = '0;
            x1 = s.first_x;
            y1 = s.first_y;
            x2 = s.second_x;
            y2 = s.second_y;
            keep = 1'b1;
            if (s.action == ACT_POINT)
            begin
                for (int k = 0; k < NUM_EDGES; k++)
                    if (side_of(k, x1, y1) >= 0)
                        keep = 1'b0;
                r.visible = keep;
                return r;
            end
            for (int k = 0; k < NUM_EDGES && keep; k++)
            begin
                v1 = side_of(k, x1, y1);
                v2 = side_of(k, x2, y2);
                if (v1 >= 0 && v2 >= 0)
                    keep = 1'b0;
                else if (!(v1 <= 0 && v2 <= 0))
                begin
                    a = (v1 < 0) ? -v1 : v1;
                    d = a + ((v2 < 0) ? -v2 : v2);
                    nx = crossing_of(x1, x2, a, d);
                    ny = crossing_of(y1, y2, a, d);
                    if (v1 >= 0)
                    begin
                        x1 = nx;
                        y1 = ny;
                    end
                    else
                    begin
                        x2 = nx;
                        y2 = ny;
                    end
                end
            end
            if (keep)
            begin
                r.visible = 1'b1;
                r.clipped_first_x = coord_t'(x1);
                r.clipped_first_y = coord_t'(y1);
                r.clipped_second_x = coord_t'(x2);
                r.clipped_second_y = coord_t'(y2);
            end
            return r;
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(99);
            if (quiet || roll < 55)
                return 0;
            if (roll < 93)
                return $urandom_range(3, 1);
            return $urandom_range(40, 8);
        end
    endfunction

    function automatic coord_t clamp_coord(longint v);
        begin
            if (v > 32767)
                return 16'sh7fff;
            if (v < -32768)
                return 16'sh8000;
            return coord_t'(v);
        end
    endfunction

    function automatic coord_t near_coord(coord_t c, int span);
        begin
            return clamp_coord(longint'(c) + $signed($urandom_range(2 * span)) - span);
        end
    endfunction

    task automatic send_segment(seg_item_t item);
        int gap;
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                seg_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            seg <= item;
            seg_valid <= 1'b1;
            @(posedge clk);
            while (!seg_ready)
                @(posedge clk);
            clip_q.push_back(clip_predict(item));
        end
    endtask

    task automatic send_fields(logic act, coord_t ax, coord_t ay, coord_t bx, coord_t by);
        seg_item_t item;
        begin
            item.action = act;
            item.first_x = ax;
            item.first_y = ay;
            item.second_x = bx;
            item.second_y = by;
            send_segment(item);
        end
    endtask

    task automatic drain_results();
        begin
            seg_valid <= 1'b0;
            while (clip_q.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic load_corners(input coord_t vals [CFG_REGS]);
        begin
            for (int i = 0; i < CFG_REGS; i++)
            begin
                cfg_we <= 1'b1;
                cfg_index <= CFG_IDX_BITS'(i);
                cfg_data <= vals[i];
                corner_q[i] = vals[i];
                @(posedge clk);
            end
            cfg_we <= 1'b0;
        end
    endtask

    task automatic load_box(longint cx, longint cy, longint hw, longint hh);
        coord_t vals [CFG_REGS];
        begin
            vals[CORNER0_X] = clamp_coord(cx - hw);
            vals[CORNER0_Y] = clamp_coord(cy - hh);
            vals[CORNER1_X] = clamp_coord(cx + hw);
            vals[CORNER1_Y] = clamp_coord(cy - hh);
            vals[CORNER2_X] = clamp_coord(cx + hw);
            vals[CORNER2_Y] = clamp_coord(cy + hh);
            vals[CORNER3_X] = clamp_coord(cx - hw);
            vals[CORNER3_Y] = clamp_coord(cy + hh);
            load_corners(vals);
        end
    endtask

    task automatic load_random_quad(bit clockwise);
        coord_t vals [CFG_REGS];
        longint cx, cy;
        int r;
        begin
            cx = $signed($urandom_range(40000)) - 20000;
            cy = $signed($urandom_range(40000)) - 20000;
            r = $urandom_range(12000, 50);
            vals[CORNER0_X] = clamp_coord(cx - $urandom_range(r, 1));
            vals[CORNER0_Y] = clamp_coord(cy - $urandom_range(r, 1));
            vals[CORNER1_X] = clamp_coord(cx + $urandom_range(r, 1));
            vals[CORNER1_Y] = clamp_coord(cy - $urandom_range(r, 1));
            vals[CORNER2_X] = clamp_coord(cx + $urandom_range(r, 1));
            vals[CORNER2_Y] = clamp_coord(cy + $urandom_range(r, 1));
            vals[CORNER3_X] = clamp_coord(cx - $urandom_range(r, 1));
            vals[CORNER3_Y] = clamp_coord(cy + $urandom_range(r, 1));
            if (clockwise)
            begin
                vals[CORNER1_X] = vals[CORNER3_X];
                vals[CORNER3_X] = clamp_coord(cx + r);
                vals[CORNER1_Y] = clamp_coord(cy + r);
                vals[CORNER3_Y] = clamp_coord(cy - r);
            end
            load_corners(vals);
        end
    endtask

    task automatic send_random_items(int count);
        int roll, span;
        longint cx, cy;
        begin
            cx = (longint'(corner_q[CORNER0_X]) + corner_q[CORNER2_X]) / 2;
            cy = (longint'(corner_q[CORNER0_Y]) + corner_q[CORNER2_Y]) / 2;
            span = 2 * ((corner_q[CORNER2_X] > corner_q[CORNER0_X]) ?
                int'(corner_q[CORNER2_X] - corner_q[CORNER0_X]) : 1000) + 16;
            for (int n = 0; n < count; n++)
            begin
                roll = $urandom_range(99);
                quiet = (n % 200) > 170;
                if (roll < 15)
                    send_fields(1'($urandom), coord_t'($urandom), coord_t'($urandom),
                        coord_t'($urandom), coord_t'($urandom));
                else if (roll < 35)
                    send_fields(ACT_POINT, near_coord(coord_t'(cx), span),
                        near_coord(coord_t'(cy), span), coord_t'($urandom),
                        coord_t'($urandom));
                else
                    send_fields(ACT_CLIP, near_coord(coord_t'(cx), span),
                        near_coord(coord_t'(cy), span), near_coord(coord_t'(cx), span),
                        near_coord(coord_t'(cy), span));
            end
            quiet = 1'b0;
        end
    endtask

    task automatic test_reset_corners();
        begin
            send_fields(ACT_CLIP, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
            send_fields(ACT_CLIP, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
            send_fields(ACT_POINT, 16'sh0001, 16'shffff, 16'sh1234, 16'sh4321);
            send_fields(ACT_POINT, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
            drain_results();
        end
    endtask

    task automatic test_box_cases();
        begin
            load_box(0, 0, 1000, 1000);
            send_fields(ACT_CLIP, -16'sd100, -16'sd200, 16'sd300, 16'sd400);
            send_fields(ACT_CLIP, 16'sd2000, 16'sd2000, 16'sd3000, -16'sd500);
            send_fields(ACT_CLIP, -16'sd3000, 16'sd7, 16'sd0, 16'sd13);
            send_fields(ACT_CLIP, 16'sd5, 16'sd3, 16'sd3001, 16'sd9);
            send_fields(ACT_CLIP, -16'sd3000, -16'sd2999, 16'sd3001, 16'sd2997);
            send_fields(ACT_CLIP, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
            send_fields(ACT_CLIP, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
            send_fields(ACT_CLIP, -16'sd1000, -16'sd1000, 16'sd1000, -16'sd1000);
            send_fields(ACT_CLIP, -16'sd1000, -16'sd500, -16'sd1000, 16'sd500);
            send_fields(ACT_CLIP, -16'sd1000, 16'sd0, 16'sd1000, 16'sd0);
            send_fields(ACT_CLIP, 16'sd1000, 16'sd1000, 16'sd1000, 16'sd1000);
            send_fields(ACT_CLIP, 16'sd1, 16'sd2000, 16'sd2, -16'sd2000);
            send_fields(ACT_POINT, 16'sd0, 16'sd0, 16'sh7fff, 16'sh8000);
            send_fields(ACT_POINT, 16'sd1000, 16'sd0, 16'sd0, 16'sd0);
            send_fields(ACT_POINT, 16'sd999, -16'sd999, 16'sd0, 16'sd0);
            send_fields(ACT_POINT, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0);
            drain_results();
            load_box(0, 0, 32767, 32767);
            send_fields(ACT_CLIP, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
            send_fields(ACT_CLIP, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
            send_fields(ACT_CLIP, 16'sh7fff, 16'sd0, 16'sh8001, 16'sd1);
            send_fields(ACT_POINT, 16'sh7ffe, 16'sh8002, 16'sd0, 16'sd0);
            send_fields(ACT_POINT, 16'sh7fff, 16'sd0, 16'sd0, 16'sd0);
            drain_results();
        end
    endtask

    task automatic test_random_quads();
        begin
            for (int p = 0; p < 5; p++)
            begin
                load_random_quad(p == 3);
                send_random_items(300);
                drain_results();
            end
        end
    endtask

    task automatic test_backpressure();
        begin
            load_random_quad(1'b0);
            long_hold_cycles = 400;
            send_random_items(200);
            drain_results();
            send_random_items(50);
            drain_results();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            rx_stall_left = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (clip_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result transfer: %p", res);
                end
                else if (res !== clip_q[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Result mismatch: expected %p, actual %p", clip_q[0], res);
                    void'(clip_q.pop_front());
                end
                else
                    void'(clip_q.pop_front());
            end
            if (long_hold_cycles > 0)
            begin
                rx_stall_left = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                res_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(99) < 30)
            begin
                rx_stall_left = ($urandom_range(99) < 90) ? $urandom_range(3, 1) :
                    $urandom_range(40, 8);
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        mismatch_count = 0;
        cycle_count = 0;
        long_hold_cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        seg_valid = 1'b0;
        seg = '0;
        for (int i = 0; i < CFG_REGS; i++)
            corner_q[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_corners();
        test_box_cases();
        test_random_quads();
        test_backpressure();
        if (mismatch_count == 0 && clip_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
